>>> rtl/core/im2dc_pkg.sv
package im2dc_pkg;

    localparam int DEVICES_DEF = 14;
    localparam int DEVICE_W    = 4;
    localparam int REQ_W       = 3;
    localparam int VECTOR_W    = 8;
    localparam int STATUS_W    = 14;
    localparam int VTOP_W      = 3;
    localparam int DMA_MASK_W  = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEV_LINE = 0;
    localparam int DEV_ULA  = 11;

    localparam logic [VECTOR_W-1:0] NO_VECTOR = 8'hff;

    localparam logic [REQ_W-1:0] REQ_RAISE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RETI  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POLL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HW_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_TOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_MASK = 2'd2;

    typedef enum logic [2:0] {
        OP_RAISE,
        OP_CLEAR,
        OP_ACK,
        OP_RETI,
        OP_POLL
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [DEVICE_W-1:0] device;
        logic                dev_ok;
        logic                qualified;
        logic                pulse;
        logic                cpu_im2;
    } item_t;

endpackage

>>> rtl/core/im2dc_front.sv
module im2dc_front #(
    parameter int DEVICES = im2dc_pkg::DEVICES_DEF
) (
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [im2dc_pkg::REQ_W-1:0]    req_type,
    input  logic [im2dc_pkg::DEVICE_W-1:0] device,
    input  logic                           qualified,
    input  logic                           pulse_capable,
    input  logic                           cpu_im2,
    input  logic                           hw_mode,
    input  logic                           q_full,
    output logic                           push,
    output im2dc_pkg::item_t               item
);
    import im2dc_pkg::*;

    localparam int CMP_W = DEVICE_W + 2;

    logic dev_ok;
    logic is_ula;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign dev_ok   = CMP_W'(device) < CMP_W'(DEVICES);
    assign is_ula   = (device == DEVICE_W'(DEV_ULA)) && dev_ok;

    always_comb
    begin
        case (req_type)
            REQ_RAISE: item.op = OP_RAISE;
            REQ_CLEAR: item.op = OP_CLEAR;
            REQ_ACK:   item.op = OP_ACK;
            REQ_RETI:  item.op = OP_RETI;
            REQ_POLL:  item.op = OP_POLL;
            default:   item.op = OP_POLL;
        endcase
        item.device    = device;
        item.dev_ok    = dev_ok;
        item.qualified = qualified;
        item.cpu_im2   = cpu_im2;
        item.pulse     = (req_type == REQ_RAISE) && dev_ok && qualified && pulse_capable
                         && (!hw_mode || (is_ula && !cpu_im2));
    end

endmodule

>>> rtl/core/im2dc_queue.sv
module im2dc_queue #(
    parameter int DEPTH = im2dc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  im2dc_pkg::item_t push_item,
    input  logic             pop,
    output im2dc_pkg::item_t pop_item,
    output logic             full,
    output logic             empty
);
    import im2dc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/im2dc_back.sv
module im2dc_back #(
    parameter int DEVICES = im2dc_pkg::DEVICES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  im2dc_pkg::item_t                 item,
    output logic                             pop,
    input  logic                             cfg_we,
    input  logic [im2dc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2dc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                             hw_mode,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             int_request,
    output logic [im2dc_pkg::VECTOR_W-1:0]   vector,
    output logic [im2dc_pkg::STATUS_W-1:0]   status_bits,
    output logic                             dma_request,
    output logic                             pulse_start
);
    import im2dc_pkg::*;

    localparam int IDX_W = $clog2(DEVICES);
    localparam int SB_W  = (DEVICES > STATUS_W) ? DEVICES : STATUS_W;

    logic                  hw_mode_reg;
    logic [VTOP_W-1:0]     vec_top_reg;
    logic [DMA_MASK_W-1:0] dma_mask_reg;

    logic [DEVICES-1:0]  latch_reg;
    logic [DEVICES-1:0]  latch_next;
    logic [DEVICES-1:0]  pend_reg;
    logic [DEVICES-1:0]  pend_next;
    logic [DEVICES-1:0]  insvc_reg;
    logic [DEVICES-1:0]  insvc_next;
    logic [VECTOR_W-1:0] last_vec_reg;
    logic [VECTOR_W-1:0] last_vec_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                int_reg;
    logic                int_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                dma_reg;
    logic                dma_next;
    logic                pulse_reg;

    logic [DEVICES-1:0]  dev_hot;
    logic [DEVICES-1:0]  chain;
    logic [DEVICES-1:0]  first_hot;
    logic [DEVICES-1:0]  grant_hot;
    logic [DEVICES-1:0]  reti_hot;
    logic [IDX_W-1:0]    grant_idx;
    logic [VECTOR_W-1:0] idx_byte;
    logic [DEVICES-1:0]  nchain;
    logic [DEVICES-1:0]  nfirst;
    logic [SB_W-1:0]     sb_wide;
    logic                line_on;
    logic                ula_on;
    logic                flags_clear;

    assign hw_mode     = hw_mode_reg;
    assign out_valid   = out_valid_reg;
    assign int_request = int_reg;
    assign vector      = last_vec_reg;
    assign status_bits = status_reg;
    assign dma_request = dma_reg;
    assign pulse_start = pulse_reg;

    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign flags_clear = cfg_we && (cfg_index == CFG_HW_MODE) && !cfg_data[0];

    always_comb
    begin
        dev_hot   = item.dev_ok ? (DEVICES'(1) << item.device) : '0;
        chain     = pend_reg | insvc_reg;
        first_hot = chain & (~chain + DEVICES'(1));
        grant_hot = first_hot & pend_reg & ~insvc_reg;
        reti_hot  = insvc_reg & (~insvc_reg + DEVICES'(1));
        grant_idx = '0;
        for (int i = 0; i < DEVICES; i++)
        begin
            if (grant_hot[i])
            begin
                grant_idx = grant_idx | IDX_W'(i);
            end
        end
        idx_byte = VECTOR_W'(grant_idx);

        latch_next    = latch_reg;
        pend_next     = pend_reg;
        insvc_next    = insvc_reg;
        last_vec_next = last_vec_reg;
        case (item.op)
            OP_RAISE:
            begin
                latch_next = latch_reg | dev_hot;
                if (item.qualified && hw_mode_reg)
                begin
                    pend_next = pend_reg | dev_hot;
                end
            end
            OP_CLEAR:
            begin
                latch_next = latch_reg & ~dev_hot;
            end
            OP_ACK:
            begin
                last_vec_next = NO_VECTOR;
                if (hw_mode_reg && |grant_hot)
                begin
                    insvc_next    = insvc_reg | grant_hot;
                    last_vec_next = {vec_top_reg, 5'b0} | {idx_byte[VECTOR_W-2:0], 1'b0};
                end
            end
            OP_RETI:
            begin
                insvc_next = insvc_reg & ~reti_hot;
                pend_next  = pend_reg & ~reti_hot;
            end
            OP_POLL:
            begin
            end
            default:
            begin
            end
        endcase

        nchain   = pend_next | insvc_next;
        nfirst   = nchain & (~nchain + DEVICES'(1));
        int_next = hw_mode_reg && item.cpu_im2 && |(nfirst & pend_next & ~insvc_next);

        line_on  = |(nchain & (DEVICES'(1) << DEV_LINE));
        ula_on   = |(nchain & (DEVICES'(1) << DEV_ULA));
        dma_next = (dma_mask_reg[1] && line_on) || (dma_mask_reg[0] && ula_on);

        sb_wide     = SB_W'(latch_next | pend_next);
        status_next = sb_wide[STATUS_W-1:0];

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_mode_reg   <= 1'b0;
            vec_top_reg   <= '0;
            dma_mask_reg  <= '0;
            latch_reg     <= '0;
            pend_reg      <= '0;
            insvc_reg     <= '0;
            last_vec_reg  <= NO_VECTOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                latch_reg    <= latch_next;
                last_vec_reg <= last_vec_next;
            end
            if (flags_clear)
            begin
                pend_reg  <= '0;
                insvc_reg <= '0;
            end
            else if (pop)
            begin
                pend_reg  <= pend_next;
                insvc_reg <= insvc_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HW_MODE:  hw_mode_reg  <= cfg_data[0];
                    CFG_VEC_TOP:  vec_top_reg  <= cfg_data[VTOP_W-1:0];
                    CFG_DMA_MASK: dma_mask_reg <= cfg_data[DMA_MASK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            int_reg    <= int_next;
            status_reg <= status_next;
            dma_reg    <= dma_next;
            pulse_reg  <= item.pulse;
        end
    end

endmodule

>>> rtl/core/im2_daisy_chain_interrupt_controller_top.sv
// A request is queued; once popped, its result is registered. Throughput: one
// request per cycle while in_stall is low; the 2-entry queue between front and back
// absorbs output stalls, and the priority scan of the flag registers sets the cycle.
// Reset: status latches, pending and in-service flags clear, vector reads 255,
// configuration returns to zero and the queue and output register empty.
module im2_daisy_chain_interrupt_controller_top #(
    parameter int DEVICES = im2dc_pkg::DEVICES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [im2dc_pkg::REQ_W-1:0]      req_type,
    input  logic [im2dc_pkg::DEVICE_W-1:0]   device,
    input  logic                             qualified,
    input  logic                             pulse_capable,
    input  logic                             cpu_im2,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             int_request,
    output logic [im2dc_pkg::VECTOR_W-1:0]   vector,
    output logic [im2dc_pkg::STATUS_W-1:0]   status_bits,
    output logic                             dma_request,
    output logic                             pulse_start,
    input  logic                             cfg_we,
    input  logic [im2dc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [im2dc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import im2dc_pkg::*;

    item_t front_item;
    item_t back_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    logic  hw_mode;

    im2dc_front #(
        .DEVICES(DEVICES)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .device        (device),
        .qualified     (qualified),
        .pulse_capable (pulse_capable),
        .cpu_im2       (cpu_im2),
        .hw_mode       (hw_mode),
        .q_full        (q_full),
        .push          (push),
        .item          (front_item)
    );

    im2dc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (back_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    im2dc_back #(
        .DEVICES(DEVICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .item        (back_item),
        .pop         (pop),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .hw_mode     (hw_mode),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .int_request (int_request),
        .vector      (vector),
        .status_bits (status_bits),
        .dma_request (dma_request),
        .pulse_start (pulse_start)
    );

endmodule

>>> rtl/core/im2dc_checker.sv
module im2dc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             int_request,
    input  logic [im2dc_pkg::VECTOR_W-1:0]   vector,
    input  logic [im2dc_pkg::STATUS_W-1:0]   status_bits,
    input  logic                             dma_request,
    input  logic                             pulse_start
);
    import im2dc_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vector) && $stable(status_bits)
            && $stable(int_request) && $stable(dma_request) && $stable(pulse_start))
    else $error("stalled result changed");

    // a granted vector always has bit 0 clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vector == NO_VECTOR) || !vector[0])
    else $error("malformed vector");

    // a pulse start and a chain INT never come from the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pulse_start && int_request))
    else $error("pulse start together with chain INT");

    // the input side never stalls while the output side is empty and free
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !out_stall && $past(!out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled with an idle output");

endmodule

bind im2_daisy_chain_interrupt_controller_top im2dc_checker u_checker (.*);

>>> tb/tb_im2_daisy_chain_interrupt_controller_top.sv
`timescale 1ns / 1ps

module tb_im2_daisy_chain_interrupt_controller_top;

    import im2dc_pkg::*;

    localparam int DEVICES     = DEVICES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 232;
    localparam int DRAIN_WAIT  = 10;

    localparam logic [REQ_W-1:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]    op;
        logic [DEVICE_W-1:0] dev;
        logic                qual;
        logic                pcap;
        logic                cim2;
    } request_t;

    typedef struct packed {
        logic                irq;
        logic [VECTOR_W-1:0] vec;
        logic [STATUS_W-1:0] stat;
        logic                dma;
        logic                pulse;
    } outcome_t;

    typedef struct packed {
        logic                  cfg_first;
        logic                  hw;
        logic [VTOP_W-1:0]     vtop;
        logic [DMA_MASK_W-1:0] mask;
        request_t              req;
        logic                  typed;
        outcome_t              want;
    } plan_row_t;

    localparam outcome_t NONE = '0;

    localparam plan_row_t PLAN [25] = '{
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_POLL, 4'd0, 1'b0, 1'b0, 1'b0},
          1'b1, '{1'b0, NO_VECTOR, 14'h0000, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd13, 1'b1, 1'b1, 1'b0},
          1'b1, '{1'b0, NO_VECTOR, 14'h2000, 1'b0, 1'b1}},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd15, 1'b1, 1'b1, 1'b1},
          1'b1, '{1'b0, NO_VECTOR, 14'h2000, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_CLEAR, 4'd13, 1'b0, 1'b0, 1'b0},
          1'b1, '{1'b0, NO_VECTOR, 14'h0000, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b1, 1'b1, 1'b1},
          1'b1, '{1'b0, NO_VECTOR, 14'h0000, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RSVD_HI, 4'd15, 1'b1, 1'b1, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd0, 1'b1, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b1, 1'b1, 3'd7, 2'd3, '{REQ_RAISE, 4'd0, 1'b1, 1'b1, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd11, 1'b1, 1'b1, 1'b0}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd5, 1'b0, 1'b1, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RETI, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RAISE, 4'd12, 1'b1, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_CLEAR, 4'd5, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RETI, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_CLEAR, 4'd14, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RSVD_LO, 4'd8, 1'b1, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RETI, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_RSVD_MID, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b1, 1'b0, 3'd0, 2'd0, '{REQ_POLL, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE},
        '{1'b1, 1'b1, 3'd0, 2'd1, '{REQ_RAISE, 4'd13, 1'b1, 1'b1, 1'b1}, 1'b0, NONE},
        '{1'b0, 1'b0, 3'd0, 2'd0, '{REQ_ACK, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NONE}
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type      = REQ_POLL;
    logic [DEVICE_W-1:0]   device        = '0;
    logic                  qualified     = 1'b0;
    logic                  pulse_capable = 1'b0;
    logic                  cpu_im2       = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  int_request;
    logic [VECTOR_W-1:0]   vector;
    logic [STATUS_W-1:0]   status_bits;
    logic                  dma_request;
    logic                  pulse_start;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_HW_MODE;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic [DEVICES-1:0]    chain_latch   = '0;
    logic [DEVICES-1:0]    chain_pend    = '0;
    logic [DEVICES-1:0]    chain_busy    = '0;
    logic [VECTOR_W-1:0]   chain_vector  = NO_VECTOR;
    logic                  chain_hw      = 1'b0;
    logic [VTOP_W-1:0]     chain_vtop    = '0;
    logic [DMA_MASK_W-1:0] chain_dmask   = '0;

    outcome_t outcomes_due [$];
    int       failures = 0;
    int       cycles   = 0;
    int       stall_mode = 0;

    im2_daisy_chain_interrupt_controller_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .device       (device),
        .qualified    (qualified),
        .pulse_capable(pulse_capable),
        .cpu_im2      (cpu_im2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .int_request  (int_request),
        .vector       (vector),
        .status_bits  (status_bits),
        .dma_request  (dma_request),
        .pulse_start  (pulse_start),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int next_grant();
        for (int i = 0; i < DEVICES; i++)
        begin
            if (chain_busy[i])
                return -1;
            if (chain_pend[i])
                return i;
        end
        return -1;
    endfunction

    task automatic predict_chain(input request_t r, output outcome_t y);
        int   g;
        logic ok;
        logic done;
        ok   = (r.dev < DEVICES);
        done = 1'b0;
        y    = '0;
        case (r.op)
            REQ_RAISE:
            begin
                if (ok)
                begin
                    chain_latch[r.dev] = 1'b1;
                    if (r.qual)
                    begin
                        if (chain_hw)
                        begin
                            chain_pend[r.dev] = 1'b1;
                            if (r.pcap && r.dev == DEV_ULA && !r.cim2)
                                y.pulse = 1'b1;
                        end
                        else if (r.pcap)
                            y.pulse = 1'b1;
                    end
                end
            end
            REQ_CLEAR:
            begin
                if (ok)
                    chain_latch[r.dev] = 1'b0;
            end
            REQ_ACK:
            begin
                chain_vector = NO_VECTOR;
                if (chain_hw)
                begin
                    g = next_grant();
                    if (g >= 0)
                    begin
                        chain_busy[g] = 1'b1;
                        chain_vector  = {chain_vtop, 4'(g), 1'b0};
                    end
                end
            end
            REQ_RETI:
            begin
                for (int i = 0; i < DEVICES; i++)
                begin
                    if (!done && chain_busy[i])
                    begin
                        chain_busy[i] = 1'b0;
                        chain_pend[i] = 1'b0;
                        done          = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        y.irq  = chain_hw && r.cim2 && (next_grant() >= 0);
        y.vec  = chain_vector;
        y.stat = chain_latch | chain_pend;
        y.dma  = (chain_dmask[1] && (chain_pend[DEV_LINE] || chain_busy[DEV_LINE])) ||
                 (chain_dmask[0] && (chain_pend[DEV_ULA] || chain_busy[DEV_ULA]));
    endtask

    // hold the request until taken, then queue its outcome
    task automatic send(input request_t r, input logic typed, input outcome_t want);
        outcome_t y;
        in_valid      <= 1'b1;
        req_type      <= r.op;
        device        <= r.dev;
        qualified     <= r.qual;
        pulse_capable <= r.pcap;
        cpu_im2       <= r.cim2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_chain(r, y);
        outcomes_due.push_back(typed ? want : y);
    endtask

    task automatic load_config(input logic hw, input logic [VTOP_W-1:0] vt,
                               input logic [DMA_MASK_W-1:0] dm);
        wait (outcomes_due.size() == 0);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HW_MODE;
        cfg_data  <= CFG_DATA_W'(hw);
        @(posedge clk);
        chain_hw = hw;
        if (!hw)
        begin
            chain_pend = '0;
            chain_busy = '0;
        end
        cfg_index <= CFG_VEC_TOP;
        cfg_data  <= CFG_DATA_W'(vt);
        @(posedge clk);
        chain_vtop = vt;
        cfg_index <= CFG_DMA_MASK;
        cfg_data  <= CFG_DATA_W'(dm);
        @(posedge clk);
        chain_dmask = dm;
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            if (cycles % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (cycles % 4 == 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
            end
            else
            begin
                e = outcomes_due.pop_front();
                if (int_request !== e.irq)
                begin
                    $error("int_request: expected %0d, got %0d", e.irq, int_request);
                    failures++;
                end
                if (vector !== e.vec)
                begin
                    $error("vector: expected %0h, got %0h", e.vec, vector);
                    failures++;
                end
                if (status_bits !== e.stat)
                begin
                    $error("status_bits: expected %0h, got %0h", e.stat, status_bits);
                    failures++;
                end
                if (dma_request !== e.dma)
                begin
                    $error("dma_request: expected %0d, got %0d", e.dma, dma_request);
                    failures++;
                end
                if (pulse_start !== e.pulse)
                begin
                    $error("pulse_start: expected %0d, got %0d", e.pulse, pulse_start);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        request_t              r;
        logic                  hw;
        logic [VTOP_W-1:0]     vt;
        logic [DMA_MASK_W-1:0] dm;
        int                    burst;
        int                    gap;
        int                    pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[k])
        begin
            if (PLAN[k].cfg_first)
            begin
                in_valid <= 1'b0;
                load_config(PLAN[k].hw, PLAN[k].vtop, PLAN[k].mask);
            end
            send(PLAN[k].req, PLAN[k].typed, PLAN[k].want);
        end
        in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: {hw, vt, dm} = {1'b1, 3'd7, 2'd3};
                1: {hw, vt, dm} = {1'b0, 3'd0, 2'd0};
                2: {hw, vt, dm} = {1'b1, 3'd0, 2'd0};
                default:
                begin
                    hw = ($urandom_range(0, 4) != 0);
                    vt = VTOP_W'($urandom_range(0, 7));
                    dm = DMA_MASK_W'($urandom_range(0, 3));
                end
            endcase
            load_config(hw, vt, dm);
            burst = $urandom_range(1, 12);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    r.op = REQ_RAISE;
                else if (pick < 55)
                    r.op = REQ_ACK;
                else if (pick < 70)
                    r.op = REQ_RETI;
                else if (pick < 80)
                    r.op = REQ_CLEAR;
                else if (pick < 92)
                    r.op = REQ_POLL;
                else
                    r.op = REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    r.dev = DEVICE_W'($urandom_range(DEVICES, 15));
                else if (pick < 40)
                    r.dev = DEVICE_W'($urandom_range(0, 3));
                else if (pick < 55)
                    r.dev = DEVICE_W'(DEV_ULA);
                else
                    r.dev = DEVICE_W'($urandom_range(0, DEVICES - 1));
                r.qual = ($urandom_range(0, 4) != 0);
                r.pcap = 1'($urandom_range(0, 1));
                r.cim2 = ($urandom_range(0, 3) != 0);
                send(r, 1'b0, NONE);
                // every third phase runs back to back
                if (ph % 3 != 2)
                begin
                    burst--;
                    if (burst == 0)
                    begin
                        burst = $urandom_range(1, 12);
                        gap   = $urandom_range(0, 5);
                        if (gap > 0)
                        begin
                            in_valid <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                    end
                end
            end
            in_valid <= 1'b0;
        end

        wait (outcomes_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && outcomes_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/im2dc_pkg.sv
rtl/core/im2dc_front.sv
rtl/core/im2dc_queue.sv
rtl/core/im2dc_back.sv
rtl/core/im2_daisy_chain_interrupt_controller_top.sv
rtl/core/im2dc_checker.sv
tb/tb_im2_daisy_chain_interrupt_controller_top.sv
